[rtl/core/byte_ring_fifo_unit_defines.svh]
// Assertion macros used by the byte ring FIFO back end (brf_back).
// Each macro expects clk and rst to be visible where it is used.
`ifndef BYTE_RING_FIFO_UNIT_DEFINES_SVH
`define BYTE_RING_FIFO_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/brf_pkg.sv]
package brf_pkg;

  localparam int DEPTH_DEFAULT    = 1024;
  localparam int MAX_READ_DEFAULT = 64;

  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 11;
  localparam int LEN_W      = 11;
  localparam int REQ_W      = 7;
  localparam int ADDR_MAX_W = 15;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DROP  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // What the back end has to do with a queued command.
  typedef enum logic [1:0] {
    CMD_NOTE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [BYTE_W-1:0]       data;
    logic [ADDR_MAX_W-1:0]   addr;
    logic [REQ_W-1:0]        count;
    status_t                 status;
    logic [CNT_W-1:0]        used;
    logic [CNT_W-1:0]        free;
  } cmd_t;

  // Advance a ring index, wrapping at the programmed size.
  function automatic logic [ADDR_MAX_W-1:0] ring_next(input logic [ADDR_MAX_W-1:0] idx,
                                                      input logic [ADDR_MAX_W-1:0] size);
    logic [ADDR_MAX_W:0] n;
    n = {1'b0, idx} + {{ADDR_MAX_W{1'b0}}, 1'b1};
    return (n >= {1'b0, size}) ? '0 : n[ADDR_MAX_W-1:0];
  endfunction

endpackage

[rtl/core/brf_ram.sv]
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/brf_cmd_queue.sv]
module brf_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  brf_pkg::cmd_t push_cmd,
  input  logic          pop,
  output brf_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  import brf_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

[rtl/core/brf_front.sv]
module brf_front #(
  parameter int DEPTH    = brf_pkg::DEPTH_DEFAULT,
  parameter int MAX_READ = brf_pkg::MAX_READ_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [1:0]                     action,
  input  logic [7:0]                     data_byte,
  input  logic [10:0]                    burst_len,
  input  logic                           first_of_burst,
  input  logic [6:0]                     read_count,
  input  logic [6:0]                     read_limit,
  input  logic                           cfg_wr_en,
  input  logic [10:0]                    cfg_wr_data,
  input  logic                           q_full,
  output logic                           push,
  output brf_pkg::cmd_t                  push_cmd,
  output logic [$clog2(DEPTH+1)-1:0]     buffer_size
);

  import brf_pkg::*;

  localparam int SW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int CW = (SW > CNT_W) ? SW : CNT_W;

  logic [IW-1:0]    wr_idx;
  logic [IW-1:0]    rd_idx;
  logic [LEN_W-1:0] burst_remaining;
  logic             burst_dropping;

  logic [IW-1:0]    wr_idx_next;
  logic [IW-1:0]    rd_idx_next;
  logic [LEN_W-1:0] burst_remaining_next;
  logic             burst_dropping_next;

  logic [SW-1:0]    used;
  logic [SW-1:0]    free;
  logic [SW-1:0]    used_after;
  logic             new_burst;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] rem_base;
  logic             drop;
  logic [CW-1:0]    req;
  logic [REQ_W-1:0] n;
  logic [SW:0]      rd_sum;
  logic [CW-1:0]    cfg_ext;
  logic [SW-1:0]    size_clamped;

  function automatic logic [SW-1:0] ring_used(input logic [IW-1:0] w,
                                              input logic [IW-1:0] r,
                                              input logic [SW-1:0] s);
    logic [SW:0] t;
    t = {1'b0, s} + (SW+1)'(w) - (SW+1)'(r);
    return (w >= r) ? (SW'(w) - SW'(r)) : t[SW-1:0];
  endfunction

  assign push = start && !q_full;
  assign used = ring_used(wr_idx, rd_idx, buffer_size);
  assign free = buffer_size - used;

  // A value of zero is taken as one, anything above the store depth as the depth.
  assign cfg_ext      = CW'(cfg_wr_data);
  assign size_clamped = (cfg_ext == '0) ? SW'(1) :
                        (cfg_ext > CW'(DEPTH)) ? SW'(DEPTH) : SW'(cfg_ext);

  always_comb begin
    wr_idx_next          = wr_idx;
    rd_idx_next          = rd_idx;
    burst_remaining_next = burst_remaining;
    burst_dropping_next  = burst_dropping;
    used_after           = used;
    push_cmd             = '0;
    push_cmd.kind        = CMD_NOTE;
    push_cmd.status      = STAT_OK;

    // Write burst bookkeeping; the space check is made on the first beat only.
    new_burst = first_of_burst || (burst_remaining == '0);
    len       = first_of_burst ? ((burst_len == '0) ? LEN_W'(1) : burst_len) : LEN_W'(1);
    drop      = new_burst ? !(CW'(free) > CW'(len)) : burst_dropping;
    rem_base  = new_burst ? len : burst_remaining;

    // Bytes delivered: the least of request, limit, stored bytes and the cap.
    req = CW'(read_count);
    if (CW'(read_limit) < req) begin
      req = CW'(read_limit);
    end
    if (CW'(used) < req) begin
      req = CW'(used);
    end
    if (CW'(MAX_READ) < req) begin
      req = CW'(MAX_READ);
    end
    n      = REQ_W'(req);
    rd_sum = (SW+1)'(rd_idx) + (SW+1)'(n);

    case (action_t'(action))
      ACT_WRITE: begin
        if (!drop) begin
          wr_idx_next = IW'(ring_next(ADDR_MAX_W'(wr_idx), ADDR_MAX_W'(buffer_size)));
        end
        burst_remaining_next = rem_base - LEN_W'(1);
        burst_dropping_next  = drop && (burst_remaining_next != '0);
        used_after           = ring_used(wr_idx_next, rd_idx, buffer_size);
        push_cmd.kind        = drop ? CMD_NOTE : CMD_WRITE;
        push_cmd.status      = drop ? STAT_DROP : STAT_OK;
        push_cmd.addr        = ADDR_MAX_W'(wr_idx);
        push_cmd.data        = data_byte;
      end
      ACT_READ, ACT_PEEK: begin
        if (n == '0) begin
          push_cmd.status = (used == '0) ? STAT_EMPTY : STAT_OK;
        end else begin
          push_cmd.kind  = CMD_READ;
          push_cmd.addr  = ADDR_MAX_W'(rd_idx);
          push_cmd.count = n;
          if (action_t'(action) == ACT_READ) begin
            used_after  = used - SW'(n);
            rd_idx_next = (rd_sum >= {1'b0, buffer_size}) ?
                          IW'(rd_sum - {1'b0, buffer_size}) : IW'(rd_sum);
          end
        end
      end
      default: begin
      end
    endcase

    push_cmd.used = CNT_W'(used_after);
    push_cmd.free = CNT_W'(buffer_size - used_after);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size     <= SW'(DEPTH);
      wr_idx          <= '0;
      rd_idx          <= '0;
      burst_remaining <= '0;
      burst_dropping  <= 1'b0;
    end else if (cfg_wr_en) begin
      buffer_size     <= size_clamped;
      wr_idx          <= '0;
      rd_idx          <= '0;
      burst_remaining <= '0;
      burst_dropping  <= 1'b0;
    end else if (push) begin
      wr_idx          <= wr_idx_next;
      rd_idx          <= rd_idx_next;
      burst_remaining <= burst_remaining_next;
      burst_dropping  <= burst_dropping_next;
    end
  end

endmodule

[rtl/core/brf_back.sv]
`include "byte_ring_fifo_unit_defines.svh"

module brf_back #(
  parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  brf_pkg::cmd_t              head,
  input  logic [$clog2(DEPTH+1)-1:0] buffer_size,
  output logic                       pop,
  output logic                       result_valid,
  output logic [7:0]                 out_byte,
  output logic                       byte_valid,
  output logic                       last,
  output logic [1:0]                 status,
  output logic [10:0]                used_count,
  output logic [10:0]                free_count
);

  import brf_pkg::*;

  localparam int IW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } back_state_t;

  back_state_t       state;
  logic [IW-1:0]     idx;
  logic [REQ_W-1:0]  rem;
  logic [CNT_W-1:0]  rd_used;
  logic [CNT_W-1:0]  rd_free;

  logic              res_valid;
  logic              res_byte_valid;
  logic              res_last;
  status_t           res_status;
  logic [CNT_W-1:0]  res_used;
  logic [CNT_W-1:0]  res_free;

  logic [IW-1:0]     ram_addr;
  logic              ram_we;
  logic [BYTE_W-1:0] ram_rdata;
  logic              emit;
  logic              emit_bv;
  logic              emit_last;
  status_t           emit_status;
  logic [CNT_W-1:0]  emit_used;
  logic [CNT_W-1:0]  emit_free;
  logic [IW-1:0]     idx_step;

  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (head.data),
    .rdata (ram_rdata)
  );

  assign pop      = (state == ST_IDLE) && !q_empty;
  assign ram_we   = pop && (head.kind == CMD_WRITE);
  assign ram_addr = (state == ST_READ) ? idx : IW'(head.addr);
  assign idx_step = IW'(ring_next(ADDR_MAX_W'(ram_addr), ADDR_MAX_W'(buffer_size)));

  always_comb begin
    emit = pop || (state == ST_READ);
    if (state == ST_READ) begin
      emit_bv     = 1'b1;
      emit_last   = (rem == REQ_W'(1));
      emit_status = STAT_OK;
      emit_used   = rd_used;
      emit_free   = rd_free;
    end else begin
      emit_bv     = (head.kind == CMD_READ);
      emit_last   = (head.kind != CMD_READ) || (head.count == REQ_W'(1));
      emit_status = head.status;
      emit_used   = head.used;
      emit_free   = head.free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      res_valid <= emit;
      case (state)
        ST_IDLE: begin
          if (pop && (head.kind == CMD_READ) && (head.count != REQ_W'(1))) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (rem == REQ_W'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Read walk: the first byte is fetched on the pop, the rest one per cycle.
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      idx <= idx_step;
      rem <= rem - REQ_W'(1);
    end else if (pop) begin
      idx     <= idx_step;
      rem     <= head.count - REQ_W'(1);
      rd_used <= head.used;
      rd_free <= head.free;
    end
    res_byte_valid <= emit_bv;
    res_last       <= emit_last;
    res_status     <= emit_status;
    res_used       <= emit_used;
    res_free       <= emit_free;
  end

  assign result_valid = res_valid;
  assign out_byte     = res_byte_valid ? ram_rdata : '0;
  assign byte_valid   = res_byte_valid;
  assign last         = res_last;
  assign status       = res_status;
  assign used_count   = res_used;
  assign free_count   = res_free;

  `BRF_ASSERT_NOW(a_read_has_bytes, state == ST_READ, rem != '0, "read walk with no bytes left")
  `BRF_ASSERT_NEXT(a_read_ends, (state == ST_READ) && (rem == REQ_W'(1)), state == ST_IDLE, "read walk did not end after its last beat")
  `BRF_ASSERT_NOW(a_plain_is_last, res_valid && !res_byte_valid, res_last, "result without a byte not marked last")
  `BRF_ASSERT_NOW(a_byte_ok, res_valid && res_byte_valid, res_status == STAT_OK, "byte beat with a non-zero status")

endmodule

[rtl/core/byte_ring_fifo_unit.sv]
// Byte FIFO on a ring whose size is programmable from 1 up to DEPTH bytes.
// Items arrive on start with action, data_byte, burst_len, first_of_burst,
// read_count and read_limit; an item is taken on a clock edge where start is
// high and busy is low. A write byte, a query, and any read or peek that
// returns no byte give one result beat; a read or peek of n bytes gives n
// beats on consecutive cycles, the final one marked by last. Every beat is
// shown for one cycle with result_valid high and cannot be held off.
// A taken item enters the command queue and its first beat leaves the
// registered output stage. Writes and queries run at one item per cycle while
// busy is low. A read or peek of n bytes holds the back end for one byte
// store access per byte, and items queue behind it in a two-entry command
// queue; busy rises when it is full. The user writes the buffer_size register
// through cfg_wr_en and cfg_wr_data only while the unit is idle; the block
// does not enforce this. A write clears both ring indices and any burst.
// Synchronous reset empties the ring, the queue and the output stage and
// sets the size to DEPTH. The byte store itself is not cleared.
module byte_ring_fifo_unit #(
  parameter int DEPTH    = brf_pkg::DEPTH_DEFAULT,
  parameter int MAX_READ = brf_pkg::MAX_READ_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  input  logic [10:0] burst_len,
  input  logic        first_of_burst,
  input  logic [6:0]  read_count,
  input  logic [6:0]  read_limit,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  output logic        result_valid,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last,
  output logic [1:0]  status,
  output logic [10:0] used_count,
  output logic [10:0] free_count
);

  import brf_pkg::*;

  localparam int SW = $clog2(DEPTH + 1);

  logic          push;
  cmd_t          push_cmd;
  cmd_t          head;
  logic          q_full;
  logic          q_empty;
  logic          pop;
  logic [SW-1:0] buffer_size;

  assign busy = q_full;

  brf_front #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .action         (action),
    .data_byte      (data_byte),
    .burst_len      (burst_len),
    .first_of_burst (first_of_burst),
    .read_count     (read_count),
    .read_limit     (read_limit),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .q_full         (q_full),
    .push           (push),
    .push_cmd       (push_cmd),
    .buffer_size    (buffer_size)
  );

  brf_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  brf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (head),
    .buffer_size  (buffer_size),
    .pop          (pop),
    .result_valid (result_valid),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .last         (last),
    .status       (status),
    .used_count   (used_count),
    .free_count   (free_count)
  );

endmodule

[tb/brf_result_checker.sv]
`timescale 1ns / 1ps

module brf_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  input  logic [10:0] burst_len,
  input  logic        first_of_burst,
  input  logic [6:0]  read_count,
  input  logic [6:0]  read_limit,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        result_valid,
  input  logic [7:0]  out_byte,
  input  logic        byte_valid,
  input  logic        last,
  input  logic [1:0]  status,
  input  logic [10:0] used_count,
  input  logic [10:0] free_count,
  output int          mismatches,
  output int          beats_due
);
  import brf_pkg::*;

  localparam int RING_DEPTH = DEPTH_DEFAULT;
  localparam int READ_CAP   = MAX_READ_DEFAULT;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              valid;
    logic              last;
    status_t           status;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  free;
  } fifo_beat_t;

  fifo_beat_t        expected_beats[$];
  logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
  int                ring_size;
  int                rd_idx;
  int                wr_idx;
  int                burst_left;
  logic              dropping;

  function automatic int ring_used();
    return (wr_idx >= rd_idx) ? wr_idx - rd_idx : ring_size + wr_idx - rd_idx;
  endfunction

  function automatic int ring_step(input int idx);
    return (idx + 1 >= ring_size) ? 0 : idx + 1;
  endfunction

  function automatic void clear_ring(input int size);
    ring_size  = size;
    rd_idx     = 0;
    wr_idx     = 0;
    burst_left = 0;
    dropping   = 1'b0;
  endfunction

  // Levels are those after the item has taken effect.
  function automatic void push_beat(input logic [7:0] b, input logic v, input logic l,
                                    input status_t s);
    fifo_beat_t e;
    int u;
    u = ring_used();
    e.data   = b;
    e.valid  = v;
    e.last   = l;
    e.status = s;
    e.used   = u[CNT_W-1:0];
    e.free   = 11'(ring_size - u);
    expected_beats.push_back(e);
  endfunction

  function automatic void predict_item();
    int         len;
    int         n;
    int         idx;
    logic [7:0] got [READ_CAP];
    status_t    st;
    case (action_t'(action))
      ACT_WRITE: begin
        st = STAT_OK;
        // A first byte, or a stray byte with no burst open, starts a burst.
        if (first_of_burst || burst_left == 0) begin
          len = first_of_burst ? int'(burst_len) : 1;
          if (len == 0) len = 1;
          dropping   = (ring_size - ring_used()) <= len;
          burst_left = len;
        end
        if (dropping) begin
          st = STAT_DROP;
        end else begin
          ring_mem[wr_idx] = data_byte;
          wr_idx = ring_step(wr_idx);
        end
        burst_left--;
        if (burst_left == 0) dropping = 1'b0;
        push_beat(8'h00, 1'b0, 1'b1, st);
      end
      ACT_READ, ACT_PEEK: begin
        n = read_count;
        if (n > read_limit) n = read_limit;
        if (n > ring_used()) n = ring_used();
        if (n > READ_CAP) n = READ_CAP;
        if (n == 0) begin
          push_beat(8'h00, 1'b0, 1'b1, (ring_used() == 0) ? STAT_EMPTY : STAT_OK);
        end else begin
          idx = rd_idx;
          for (int k = 0; k < n; k++) begin
            got[k] = ring_mem[idx];
            idx = ring_step(idx);
          end
          if (action_t'(action) == ACT_READ) rd_idx = idx;
          for (int k = 0; k < n; k++) push_beat(got[k], 1'b1, k == n - 1, STAT_OK);
        end
      end
      default: push_beat(8'h00, 1'b0, 1'b1, STAT_OK);
    endcase
  endfunction

  always @(posedge clk) begin
    fifo_beat_t seen;
    fifo_beat_t want;
    int size;
    if (rst) begin
      clear_ring(RING_DEPTH);
      expected_beats.delete();
    end else begin
      // Beats leaving now belong to items taken earlier, so compare before predicting.
      if (result_valid) begin
        seen.data   = out_byte;
        seen.valid  = byte_valid;
        seen.last   = last;
        seen.status = status_t'(status);
        seen.used   = used_count;
        seen.free   = free_count;
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: byte %02h valid %0b last %0b status %0d used %0d free %0d",
                     seen.data, seen.valid, seen.last, seen.status, seen.used, seen.free);
        end else begin
          want = expected_beats.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result beat mismatch at %0t", $realtime);
              $display("  expected byte %02h valid %0b last %0b status %0d used %0d free %0d",
                       want.data, want.valid, want.last, want.status, want.used, want.free);
              $display("  got      byte %02h valid %0b last %0b status %0d used %0d free %0d",
                       seen.data, seen.valid, seen.last, seen.status, seen.used, seen.free);
            end
          end
        end
      end
      if (cfg_wr_en) begin
        size = cfg_wr_data;
        if (size < 1) size = 1;
        if (size > RING_DEPTH) size = RING_DEPTH;
        clear_ring(size);
      end
      if (start && !busy) predict_item();
    end
    beats_due = expected_beats.size();
  end

endmodule

[tb/tb_byte_ring_fifo_unit.sv]
`timescale 1ns / 1ps

module tb_byte_ring_fifo_unit;
  import brf_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS   = 12;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  action_t     action;
  logic [7:0]  data_byte;
  logic [10:0] burst_len;
  logic        first_of_burst;
  logic [6:0]  read_count;
  logic [6:0]  read_limit;
  logic        cfg_wr_en;
  logic [10:0] cfg_wr_data;
  logic        result_valid;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [1:0]  status;
  logic [10:0] used_count;
  logic [10:0] free_count;

  int mismatches;
  int beats_due;
  int cycle_count;
  int items_sent;
  int pace_left;
  int ring_len;
  bit steady;

  byte_ring_fifo_unit DUT (.*);

  brf_result_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic idle_cycle();
    start <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_item(input action_t act, input logic [7:0] d, input logic [10:0] blen,
                           input logic opens, input logic [6:0] rc, input logic [6:0] rl);
    if (!steady && pace_left == 0) begin
      repeat ($urandom_range(1, 7)) idle_cycle();
      pace_left = $urandom_range(1, 16);
    end
    if (pace_left > 0) pace_left--;
    action         <= act;
    data_byte      <= d;
    burst_len      <= blen;
    first_of_burst <= opens;
    read_count     <= rc;
    read_limit     <= rl;
    start          <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_byte(input logic [7:0] d, input logic [10:0] blen, input logic opens);
    send_item(ACT_WRITE, d, blen, opens, 7'($urandom_range(0, 127)),
              7'($urandom_range(0, 127)));
  endtask

  task automatic read_op(input action_t act, input logic [6:0] rc, input logic [6:0] rl);
    send_item(act, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)),
              1'($urandom_range(0, 1)), rc, rl);
  endtask

  task automatic query_op();
    send_item(ACT_QUERY, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)),
              1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
              7'($urandom_range(0, 127)));
  endtask

  // Sends the first sent_len bytes of a burst announced as len bytes long.
  task automatic write_burst(input int len, input int sent_len);
    for (int k = 0; k < sent_len; k++)
      write_byte(8'($urandom_range(0, 255)),
                 (k == 0) ? 11'(len) : 11'($urandom_range(0, 2047)), k == 0);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (beats_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_ring_size(input logic [10:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    ring_len = (v == 0) ? 1 : (v > DEPTH_DEFAULT) ? DEPTH_DEFAULT : int'(v);
  endtask

  function automatic logic [6:0] pick_request();
    case ($urandom_range(0, 9))
      0:       return 7'd0;
      1:       return 7'($urandom_range(65, 127));
      2:       return 7'd64;
      3, 4, 5: return 7'($urandom_range(1, 8));
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic run_activity();
    int pick;
    int len;
    int top_len;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // Small rings also see bursts one byte too long for them.
      top_len = (ring_len < 24) ? ring_len + 1 : 24;
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, top_len) : $urandom_range(1, 6);
      write_burst(len, ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len);
    end else if (pick < 65) begin
      read_op(ACT_READ, pick_request(), pick_request());
    end else if (pick < 78) begin
      read_op(ACT_PEEK, pick_request(), pick_request());
    end else if (pick < 88) begin
      query_op();
    end else if (pick < 97) begin
      write_byte(8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)),
                 1'($urandom_range(0, 1)));
    end else begin
      wait_drained();
    end
  endtask

  initial begin
    logic [10:0] ring_sizes [8];
    int target;
    ring_sizes     = '{11'd0, 11'd2, 11'd5, 11'd17, 11'd2047, 11'd64, 11'd1024, 11'd3};
    rst            = 1'b1;
    start          = 1'b0;
    action         = ACT_QUERY;
    data_byte      = '0;
    burst_len      = '0;
    first_of_burst = 1'b0;
    read_count     = '0;
    read_limit     = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    ring_len       = DEPTH_DEFAULT;
    steady         = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    query_op();
    read_op(ACT_READ, 7'd64, 7'd64);
    read_op(ACT_PEEK, 7'd0, 7'd0);
    write_byte(8'h00, 11'd0, 1'b1);
    write_byte(8'hFF, 11'd3, 1'b1);
    write_byte(8'hA5, 11'd0, 1'b0);
    write_byte(8'h5A, 11'd2047, 1'b0);
    // No burst is open here, so this byte stands as a burst of its own.
    write_byte(8'h3C, 11'd1, 1'b0);
    read_op(ACT_PEEK, 7'd64, 7'd64);
    read_op(ACT_READ, 7'd0, 7'd10);
    read_op(ACT_READ, 7'd10, 7'd0);
    read_op(ACT_READ, 7'd2, 7'd127);
    write_byte(8'h81, 11'd2047, 1'b1);
    write_byte(8'h7E, 11'd0, 1'b0);
    // A full-ring burst never fits, and a fresh first byte abandons it.
    write_byte(8'h11, 11'd1024, 1'b1);
    write_byte(8'h22, 11'd2, 1'b1);
    write_byte(8'h33, 11'd0, 1'b0);
    read_op(ACT_PEEK, 7'd127, 7'd3);
    read_op(ACT_READ, 7'd127, 7'd127);
    read_op(ACT_READ, 7'd127, 7'd127);
    query_op();

    foreach (ring_sizes[p]) begin
      set_ring_size(ring_sizes[p]);
      steady = ($urandom_range(0, 3) == 0);
      if (ring_sizes[p] == 11'd1024) begin
        // Enough bytes to make one read hit the per-request cap.
        write_burst(70, 70);
        read_op(ACT_READ, 7'd127, 7'd127);
      end
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) run_activity();
    end

    wait_drained();
    if (mismatches == 0 && beats_due == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
